/* design/tlik_pkg.sv */
// Package for the two-link arm inverse kinematics block.
// Holds the request and result structs, the arctangent table and fixed Q30 constants.
// No dependencies.
package tlik_pkg;

	localparam int TableLen = 24;
	localparam int AccW = 34;
	localparam logic signed [AccW-1:0] PiQ30 = 34'sd3373259426;
	localparam logic signed [AccW-1:0] HalfPiQ30 = 34'sd1686629713;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} req_t;

	typedef struct packed {
		logic signed [16:0] base_joint_angle;
		logic signed [15:0] elbow_joint_angle;
		logic unreachable;
	} res_t;

	function automatic logic signed [AccW-1:0] atan_q30(input logic [4:0] i);
		logic signed [AccW-1:0] v;
		begin
			case (i)
				5'd0: v = 34'sh3243F6A8;
				5'd1: v = 34'sh1DAC6705;
				5'd2: v = 34'sh0FADBAFC;
				5'd3: v = 34'sh07F56EA6;
				5'd4: v = 34'sh03FEAB76;
				5'd5: v = 34'sh01FFD55B;
				5'd6: v = 34'sh00FFFAAA;
				5'd7: v = 34'sh007FFF55;
				5'd8: v = 34'sh003FFFEA;
				5'd9: v = 34'sh001FFFFD;
				5'd10: v = 34'sh000FFFFF;
				5'd11: v = 34'sh0007FFFF;
				5'd12: v = 34'sh0003FFFF;
				5'd13: v = 34'sh0001FFFF;
				5'd14: v = 34'sh0000FFFF;
				5'd15: v = 34'sh00007FFF;
				5'd16: v = 34'sh00003FFF;
				5'd17: v = 34'sh00001FFF;
				5'd18: v = 34'sh00000FFF;
				5'd19: v = 34'sh000007FF;
				5'd20: v = 34'sh000003FF;
				5'd21: v = 34'sh000001FF;
				5'd22: v = 34'sh000000FF;
				5'd23: v = 34'sh0000007F;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

/* design/tlik_front.sv */
// Front end: squares the target, classifies reach and forms the two radicands.
// Uses tlik_pkg. Three registered stages, one request per cycle, stall-all.
module tlik_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tlik_pkg::req_t  req,
	input  logic [14:0]     l1,
	input  logic [14:0]     l2,
	output logic            out_valid,
	output logic signed [15:0] x_o,
	output logic signed [15:0] y_o,
	output logic [31:0]     r2_o,
	output logic [31:0]     s2_o,
	output logic            unr_o
);
	import tlik_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic signed [15:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [31:0] xx_s1, yy_s1, r2_s2, r2_s3, s2_s3;
	logic [31:0] reach_s1, reach_s2, four_s1, four_s2;
	logic unr_s3;
	logic [15:0] lsum;

	assign lsum = {1'b0, l1} + {1'b0, l2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= req.target_x;
			y_s1 <= req.target_y;
			xx_s1 <= 32'(req.target_x * req.target_x);
			yy_s1 <= 32'(req.target_y * req.target_y);
			reach_s1 <= lsum * lsum;
			four_s1 <= {{15'd0, l1} * {15'd0, l1}, 2'b00};
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			r2_s2 <= xx_s1 + yy_s1;
			reach_s2 <= reach_s1;
			four_s2 <= four_s1;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			r2_s3 <= r2_s2;
			unr_s3 <= (r2_s2 == '0) || (r2_s2 >= reach_s2);
			s2_s3 <= (four_s2 > r2_s2) ? four_s2 - r2_s2 : '0;
		end
	end

	assign out_valid = v_s3;
	assign x_o = x_s3;
	assign y_o = y_s3;
	assign r2_o = r2_s3;
	assign s2_o = s2_s3;
	assign unr_o = unr_s3;
endmodule

/* design/tlik_queue.sv */
// Short queue between front and back ends, four entries.
// No package dependencies; the payload is a flat vector of parameter width.
module tlik_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         nempty,
	output logic [2:0]   count
);
	logic [W-1:0] mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b00, wr} - {2'b00, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign nempty = (cnt_q != '0);
	assign count = cnt_q;
endmodule

/* design/tlik_back.sv */
// Back end: two pipelined integer square roots and two pipelined vectoring CORDICs,
// then the angle combination and rounding. Uses tlik_pkg. Stall-all pipeline.
module tlik_back #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic signed [15:0] x_i,
	input  logic signed [15:0] y_i,
	input  logic [31:0]     r2_i,
	input  logic [31:0]     s2_i,
	input  logic            unr_i,
	output logic            out_valid,
	output tlik_pkg::res_t  res
);
	import tlik_pkg::*;

	localparam int NS = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
	localparam int SQ = 30;   // sqrt of a 60 bit value, one result bit per stage
	localparam int CW = 34;   // CORDIC word: coords up to 2^30 times gain
	localparam int NT = SQ + NS + 1;

	// square root stages: rem, root, radicand tails
	logic [61:0] ra_q [SQ+1];
	logic [61:0] rb_q [SQ+1];
	logic [31:0] qa_q [SQ+1];
	logic [31:0] qb_q [SQ+1];
	logic [31:0] ta_q [SQ+1];
	logic [31:0] tb_q [SQ+1];
	logic signed [15:0] xs_q [SQ+1];
	logic signed [15:0] ys_q [SQ+1];
	logic un_q [SQ+1];
	logic v_q [NT+1];

	// CORDIC stages
	logic signed [CW-1:0] ax_q [NS+1];
	logic signed [CW-1:0] ay_q [NS+1];
	logic signed [AccW-1:0] az_q [NS+1];
	logic signed [CW-1:0] bx_q [NS+1];
	logic signed [CW-1:0] by_q [NS+1];
	logic signed [AccW-1:0] bz_q [NS+1];
	logic yp_q [NS+1];
	logic uc_q [NS+1];

	logic signed [AccW+1:0] base_c, elbow_c;
	logic signed [16:0] base_s;
	logic signed [15:0] elbow_s;
	logic un_s;

	always_comb begin
		ra_q[0] = '0;
		rb_q[0] = '0;
		qa_q[0] = '0;
		qb_q[0] = '0;
		ta_q[0] = r2_i;
		tb_q[0] = s2_i;
		xs_q[0] = x_i;
		ys_q[0] = y_i;
		un_q[0] = unr_i;
		v_q[0] = in_valid;
	end

	// restoring square root of v*2^28; one digit pair per stage
	function automatic logic [93:0] sq_step(input logic [61:0] rem, input logic [31:0] root,
		input logic [1:0] dig);
		logic [63:0] r, t;
		begin
			r = {rem, dig};
			t = {root, 2'b01};
			if (r >= t) return {62'(r - t), root[30:0], 1'b1};
			return {62'(r), root[30:0], 1'b0};
		end
	endfunction

	genvar g;
	generate
		for (g = 0; g < SQ; g++) begin : g_sq
			logic [93:0] na, nb;
			logic [1:0] da, db;
			// digit pairs: 16 pairs of the 32-bit value, then 14 zero pairs
			assign da = (g < 16) ? ta_q[g][31:30] : 2'b00;
			assign db = (g < 16) ? tb_q[g][31:30] : 2'b00;
			assign na = sq_step(ra_q[g], qa_q[g], da);
			assign nb = sq_step(rb_q[g], qb_q[g], db);
			always_ff @(posedge clk) begin
				if (en) begin
					ra_q[g+1] <= na[93:32];
					qa_q[g+1] <= na[31:0];
					rb_q[g+1] <= nb[93:32];
					qb_q[g+1] <= nb[31:0];
					ta_q[g+1] <= {ta_q[g][29:0], 2'b00};
					tb_q[g+1] <= {tb_q[g][29:0], 2'b00};
					xs_q[g+1] <= xs_q[g];
					ys_q[g+1] <= ys_q[g];
					un_q[g+1] <= un_q[g];
				end
			end
		end
	endgenerate

	// CORDIC entry: alpha from (c, s) with c > 0; t from scaled target with pre-rotation
	always_comb begin
		logic signed [CW-1:0] tx, ty;
		tx = CW'(xs_q[SQ]) <<< 14;
		ty = CW'(ys_q[SQ]) <<< 14;
		ax_q[0] = CW'(qa_q[SQ]);
		ay_q[0] = CW'(qb_q[SQ]);
		az_q[0] = '0;
		if (tx < 0) begin
			if (ty >= 0) begin
				bx_q[0] = ty;
				by_q[0] = -tx;
				bz_q[0] = HalfPiQ30;
			end else begin
				bx_q[0] = -ty;
				by_q[0] = tx;
				bz_q[0] = -HalfPiQ30;
			end
		end else begin
			bx_q[0] = tx;
			by_q[0] = ty;
			bz_q[0] = '0;
		end
		yp_q[0] = ys_q[SQ] > 0;
		uc_q[0] = un_q[SQ];
	end

	generate
		for (g = 0; g < NS; g++) begin : g_cordic
			always_ff @(posedge clk) begin
				if (en) begin
					if (ay_q[g] > 0) begin
						ax_q[g+1] <= ax_q[g] + (ay_q[g] >>> g);
						ay_q[g+1] <= ay_q[g] - (ax_q[g] >>> g);
						az_q[g+1] <= az_q[g] + atan_q30(5'(g));
					end else begin
						ax_q[g+1] <= ax_q[g] - (ay_q[g] >>> g);
						ay_q[g+1] <= ay_q[g] + (ax_q[g] >>> g);
						az_q[g+1] <= az_q[g] - atan_q30(5'(g));
					end
					if (by_q[g] > 0) begin
						bx_q[g+1] <= bx_q[g] + (by_q[g] >>> g);
						by_q[g+1] <= by_q[g] - (bx_q[g] >>> g);
						bz_q[g+1] <= bz_q[g] + atan_q30(5'(g));
					end else begin
						bx_q[g+1] <= bx_q[g] - (by_q[g] >>> g);
						by_q[g+1] <= by_q[g] + (bx_q[g] >>> g);
						bz_q[g+1] <= bz_q[g] - atan_q30(5'(g));
					end
					yp_q[g+1] <= yp_q[g];
					uc_q[g+1] <= uc_q[g];
				end
			end
		end
	endgenerate

	always_comb begin
		logic signed [AccW+1:0] a, t, half;
		a = (AccW+2)'(az_q[NS]);
		t = (AccW+2)'(bz_q[NS]);
		half = (AccW+2)'(1) <<< (29 - ANGLE_FRAC_BITS);
		if (yp_q[NS]) begin
			base_c = t - a + half;
			elbow_c = (a <<< 1) - (AccW+2)'(PiQ30) + half;
		end else begin
			base_c = t + a + half;
			elbow_c = (AccW+2)'(PiQ30) - (a <<< 1) + half;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			un_s <= uc_q[NS];
			base_s <= uc_q[NS] ? '0 : 17'(base_c >>> (30 - ANGLE_FRAC_BITS));
			elbow_s <= uc_q[NS] ? '0 : 16'(elbow_c >>> (30 - ANGLE_FRAC_BITS));
		end
	end

	// valid shift line across every stage
	generate
		for (g = 0; g < NT; g++) begin : g_valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_q[g+1] <= 1'b0;
				else if (en) v_q[g+1] <= v_q[g];
			end
		end
	endgenerate

	assign out_valid = v_q[NT];
	assign res.base_joint_angle = base_s;
	assign res.elbow_joint_angle = elbow_s;
	assign res.unreachable = un_s;
endmodule

/* design/two_link_arm_inverse_kinematics.sv */
// Top level of the two-link arm inverse kinematics block.
// Uses tlik_pkg, tlik_front, tlik_queue and tlik_back.
//
// One request per clock cycle is taken while in_ready is high; one result is returned
// per request, in order. The front end (three stages) squares the target and checks
// reach against (L1+L2)^2; a four-entry queue decouples it from the back end, which runs
// two 30-stage square roots, two CORDIC pipelines of CORDIC_STEPS stages (capped at the
// table length) and one rounding stage. The back end stalls only when the result
// register is full and not taken; the front end stalls when the queue could overflow.
// Link lengths are to be written only while the block is idle; this is left to the user.
module two_link_arm_inverse_kinematics #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tlik_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tlik_pkg::res_t out_data,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [14:0]    cfg_wdata
);
	import tlik_pkg::*;

	localparam logic [0:0] RegL1 = 1'd0;
	localparam logic [0:0] RegL2 = 1'd1;
	localparam int QW = 16 + 16 + 32 + 32 + 1;

	logic [14:0] l1_q, l2_q;
	logic f_en, f_valid, f_unr;
	logic signed [15:0] f_x, f_y;
	logic [31:0] f_r2, f_s2;
	logic [2:0] q_cnt;
	logic q_nempty, q_rd, b_en, b_valid;
	logic [QW-1:0] q_data;
	res_t b_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 15'd1440;
			l2_q <= 15'd1440;
		end else if (cfg_we) begin
			case (cfg_index)
				RegL1: l1_q <= cfg_wdata;
				RegL2: l2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Front runs only while the queue has room for everything its pipeline holds.
	assign f_en = (q_cnt == 3'd0) || (q_cnt == 3'd1) ||
		((q_cnt == 3'd2) && q_rd);
	assign in_ready = f_en;

	tlik_front u_front (
		.clk, .arst_n, .en(f_en), .in_valid, .req(in_data), .l1(l1_q), .l2(l2_q),
		.out_valid(f_valid), .x_o(f_x), .y_o(f_y), .r2_o(f_r2), .s2_o(f_s2), .unr_o(f_unr)
	);

	tlik_queue #(.W(QW)) u_queue (
		.clk, .arst_n, .wr(f_en && f_valid), .wdata({f_x, f_y, f_r2, f_s2, f_unr}),
		.rd(q_rd), .rdata(q_data), .nempty(q_nempty), .count(q_cnt)
	);

	// Back end advances when its last stage is empty or being taken.
	assign b_en = !out_valid || out_ready;
	assign q_rd = b_en && q_nempty;

	tlik_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .en(b_en), .in_valid(q_rd),
		.x_i(q_data[96:81]), .y_i(q_data[80:65]), .r2_i(q_data[64:33]),
		.s2_i(q_data[32:1]), .unr_i(q_data[0]), .out_valid(b_valid), .res(b_res)
	);

	assign out_valid = b_valid;
	assign out_data = b_res;
endmodule

/* verif/tb_two_link_arm_inverse_kinematics.sv */
// Self-checking testbench for the two-link arm inverse kinematics block.
// Depends on tlik_pkg and two_link_arm_inverse_kinematics from the design folder.
`timescale 1ns / 100ps
module tb_two_link_arm_inverse_kinematics;
	import tlik_pkg::*;

	// Register indexes of the configuration port.
	localparam logic [0:0] REG_FIRST_LINK = 1'd0;
	localparam logic [0:0] REG_SECOND_LINK = 1'd1;

	// Fixed-point layout of the predictor: Q30 angles, CORDIC pre-scale and step count.
	localparam int STEPS = 16;
	localparam int OUT_FRAC = 13;
	localparam int PRE_SHIFT = 14;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	// Settle time for drain, chosen to exceed the pipeline depth.
	localparam int SETTLE_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [14:0] cfg_wdata = '0;

	two_link_arm_inverse_kinematics u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 8 ns period: four high, four low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The predictor's own copy of the link length registers.
	logic [14:0] link1_len;
	logic [14:0] link2_len;

	// Expected joint angles, oldest first, one per accepted request.
	res_t angles_q[$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_off_req = 1'b0;
	int mismatches = 0;
	int requests_taken = 0;
	int results_seen = 0;
	int unreachable_seen = 0;

	// Arctangent table in Q30, kept here so that the prediction does not lean on the design.
	longint atan_tab [STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	// Floor square root by the usual bit-pair method.
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rem, root, bit_w;
		rem = v;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem -= root + bit_w;
				root = (root >> 1) + bit_w;
			end else begin
				root >>= 1;
			end
			bit_w >>= 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC: atan2(y, x) in Q30. Vectors in the left half-plane are first turned
	// by a quarter turn so that the iterations only ever see x >= 0.
	function automatic longint cordic_atan2(input longint xi, input longint yi);
		longint x, y, z, dx, dy, t;
		x = xi;
		y = yi;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q30;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q30;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end
		end
		return z;
	endfunction

	// Round half up from Q30 down to the output fraction width.
	function automatic longint round_to_out(input longint q30);
		return (q30 + (64'sd1 <<< (29 - OUT_FRAC))) >>> (30 - OUT_FRAC);
	endfunction

	function automatic res_t joint_angles(input req_t r);
		res_t res;
		longint x, y, t, alpha, base, elbow, c, s;
		longint unsigned r2, reach, four_l1;
		x = longint'(r.target_x);
		y = longint'(r.target_y);
		r2 = longint'(x * x) + longint'(y * y);
		reach = (longint'(link1_len) + longint'(link2_len)) *
			(longint'(link1_len) + longint'(link2_len));
		res = '0;
		if (r2 == 0 || r2 >= reach) begin
			res.unreachable = 1'b1;
			return res;
		end
		four_l1 = 4 * longint'(link1_len) * longint'(link1_len);
		c = longint'(floor_sqrt(r2 << 28));
		// When the first link cannot span half the distance the half angle saturates at zero.
		s = 0;
		if (four_l1 > r2)
			s = longint'(floor_sqrt((four_l1 - r2) << 28));
		alpha = cordic_atan2(c, s);
		t = cordic_atan2(x <<< PRE_SHIFT, y <<< PRE_SHIFT);
		if (y > 0) begin
			base = t - alpha;
			elbow = -(PI_Q30 - 2 * alpha);
		end else begin
			base = t + alpha;
			elbow = PI_Q30 - 2 * alpha;
		end
		res.base_joint_angle = 17'(round_to_out(base));
		res.elbow_joint_angle = 16'(round_to_out(elbow));
		return res;
	endfunction

	// Receiver: random stalls, plus a long hold-off on request so that the block backs up.
	// The request flag is consumed here, so the hold-off starts exactly once per request.
	always @(posedge clk) begin : receiver
		int hold_left;
		if (hold_off_req && hold_left == 0) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_off_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (32'($urandom_range(99)) >= receiver_stall_pct);
		end
	end

	// Result checker. Signals are sampled at the edge, before the design's updates land.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (out_data.unreachable)
				unreachable_seen++;
			if (angles_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p with nothing outstanding", out_data);
			end else begin
				want = angles_q.pop_front();
				if (want.base_joint_angle !== out_data.base_joint_angle ||
						want.elbow_joint_angle !== out_data.elbow_joint_angle ||
						want.unreachable !== out_data.unreachable) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: base exp %0d got %0d, elbow exp %0d got %0d, unr exp %0b got %0b",
							want.base_joint_angle, out_data.base_joint_angle,
							want.elbow_joint_angle, out_data.elbow_joint_angle,
							want.unreachable, out_data.unreachable);
				end
			end
		end
	end

	// Watchdog: counts cycles with work pending but no request or result moving.
	always @(posedge clk) begin : watchdog
		int stuck;
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(!in_valid && angles_q.size() == 0))
			stuck = 0;
		else
			stuck++;
		if (stuck >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", angles_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one request after a random gap and waits for it to be taken. Valid is only lowered
	// when a gap is actually inserted, so back-to-back requests never toggle it within a step.
	task automatic send_target(input req_t r, input bit has_known, input res_t known);
		int gap;
		gap = 0;
		while (32'($urandom_range(99)) < sender_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (!in_ready);
		// Rows whose answer is obvious carry it in the table; all others use the predictor.
		angles_q.push_back(has_known ? known : joint_angles(r));
		requests_taken++;
	endtask

	// Lets the pipeline empty before registers are touched. Valid drops at the edge that
	// took the last request, so that request is not offered twice.
	task automatic drain;
		in_valid <= 1'b0;
		while (angles_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_links(input logic [14:0] l1, input logic [14:0] l2);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIRST_LINK;
		cfg_wdata <= l1;
		@(posedge clk);
		cfg_index <= REG_SECOND_LINK;
		cfg_wdata <= l2;
		@(posedge clk);
		cfg_we <= 1'b0;
		link1_len = l1;
		link2_len = l2;
		@(posedge clk);
	endtask

	// Random target: mostly within the square bounded by the current reach, the rest anywhere.
	function automatic req_t random_target;
		req_t r;
		int lim;
		lim = int'(link1_len) + int'(link2_len);
		if (lim > 32767)
			lim = 32767;
		if ($urandom_range(99) < 70) begin
			r.target_x = 16'($signed($urandom_range(2 * lim)) - lim);
			r.target_y = 16'($signed($urandom_range(2 * lim)) - lim);
		end else begin
			r.target_x = 16'($urandom);
			r.target_y = 16'($urandom);
		end
		return r;
	endfunction

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit has_known;
	} target_row_t;

	// Directed targets at reset lengths (1440 and 1440, reach 2880).
	target_row_t directed [] = '{
		'{16'sd0, 16'sd0, 1'b1},          // origin
		'{16'sd32767, 16'sd32767, 1'b1},  // far corner, out of reach
		'{-16'sd32768, -16'sd32768, 1'b1},
		'{16'sd2880, 16'sd0, 1'b1},       // exactly at full reach
		'{16'sd0, -16'sd2880, 1'b1},
		'{16'sd2879, 16'sd0, 1'b0},       // just inside reach
		'{16'sd1, 16'sd0, 1'b0},
		'{16'sd0, 16'sd1, 1'b0},
		'{-16'sd1, 16'sd0, 1'b0},         // negative x axis
		'{-16'sd2000, 16'sd0, 1'b0},
		'{16'sd0, -16'sd1, 1'b0},
		'{16'sd100, 16'sd100, 1'b0},
		'{-16'sd100, 16'sd50, 1'b0},
		'{-16'sd100, -16'sd50, 1'b0},
		'{16'sd1440, -16'sd1440, 1'b0},
		'{-16'sd2036, 16'sd2036, 1'b0},
		'{16'sd1, -16'sd2878, 1'b0},
		'{-16'sd2878, -16'sd1, 1'b0}
	};

	typedef struct {
		logic [14:0] l1;
		logic [14:0] l2;
		int send_pct;
		int recv_pct;
		int count;
		bit pressure;
	} phase_t;

	// Random phases: default arm, longest links, shortest links, a first link too short to
	// span half the distance, a zero first link under back-pressure, and an uneven long arm.
	phase_t phases [] = '{
		'{15'd1440, 15'd1440, 0, 0, 150, 1'b0},
		'{15'd32767, 15'd32767, 72, 0, 120, 1'b0},
		'{15'd1, 15'd1, 0, 72, 80, 1'b0},
		'{15'd100, 15'd3000, 23, 23, 120, 1'b0},
		'{15'd0, 15'd5000, 0, 0, 80, 1'b1},
		'{15'd20000, 15'd12767, 0, 72, 150, 1'b0}
	};

	initial begin
		res_t unreached;
		unreached = '0;
		unreached.unreachable = 1'b1;
		link1_len = 15'd1440;
		link2_len = 15'd1440;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset lengths and no idling on either side.
		foreach (directed[i]) begin
			req_t r;
			r.target_x = directed[i].x;
			r.target_y = directed[i].y;
			send_target(r, directed[i].has_known, unreached);
		end

		foreach (phases[p]) begin
			drain();
			set_links(phases[p].l1, phases[p].l2);
			sender_idle_pct = phases[p].send_pct;
			receiver_stall_pct = phases[p].recv_pct;
			// The hold-off flag is picked up by the receiver and then runs its own count.
			hold_off_req = phases[p].pressure;
			for (int k = 0; k < phases[p].count; k++)
				send_target(random_target(), 1'b0, unreached);
		end

		drain();
		$display("covered %0d requests over %0d link settings, %0d results (%0d unreachable)",
			requests_taken, phases.size() + 1, results_seen, unreachable_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && angles_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
design/tlik_pkg.sv
design/tlik_front.sv
design/tlik_queue.sv
design/tlik_back.sv
design/two_link_arm_inverse_kinematics.sv
verif/tb_two_link_arm_inverse_kinematics.sv
